// ===== rtl/lpks_pkg.sv =====
// Shared types and constants for the last-press-priority key stack.
// No dependencies; lpks_if, lpks_seq, the top level and the bench use this package.
`timescale 1ns / 1ps

package lpks_pkg;

  localparam int unsigned ENTRIES_DEF = 16;

  localparam int unsigned LIMIT_W = 5;
  localparam int unsigned POS_W   = 8;
  localparam int unsigned PARAM_W = 32;
  localparam int unsigned TIME_W  = 48;

  localparam logic [LIMIT_W-1:0] LIMIT_RST = 5'd10;

  // request codes
  localparam logic REQ_PRESS = 1'b0;

  typedef struct packed {
    logic               req_type;
    logic [POS_W-1:0]   key_position;
    logic [PARAM_W-1:0] param_a;
    logic [PARAM_W-1:0] param_b;
    logic [TIME_W-1:0]  event_time;
  } req_t;

  typedef struct packed {
    logic               is_press;
    logic [POS_W-1:0]   position;
    logic [PARAM_W-1:0] param_a;
    logic [PARAM_W-1:0] param_b;
    logic [TIME_W-1:0]  evt_time;
    logic               last;
  } ev_t;

endpackage

// ===== rtl/lpks_if.sv =====
// Valid/ready channel interfaces for key event words and emitted event words.
// Depends on lpks_pkg for field widths.
`timescale 1ns / 1ps

interface lpks_in_if;
  logic                          valid;
  logic                          ready;
  logic                          req_type;
  logic [lpks_pkg::POS_W-1:0]    key_position;
  logic [lpks_pkg::PARAM_W-1:0]  param_a;
  logic [lpks_pkg::PARAM_W-1:0]  param_b;
  logic [lpks_pkg::TIME_W-1:0]   event_time;

  modport source (output valid, req_type, key_position, param_a, param_b, event_time,
                  input ready);
  modport sink   (input valid, req_type, key_position, param_a, param_b, event_time,
                  output ready);
endinterface

interface lpks_out_if;
  logic                          valid;
  logic                          ready;
  logic                          out_is_press;
  logic [lpks_pkg::POS_W-1:0]    out_position;
  logic [lpks_pkg::PARAM_W-1:0]  out_param_a;
  logic [lpks_pkg::PARAM_W-1:0]  out_param_b;
  logic [lpks_pkg::TIME_W-1:0]   out_time;
  logic                          out_last;

  modport source (output valid, out_is_press, out_position, out_param_a, out_param_b,
                  out_time, out_last, input ready);
  modport sink   (input valid, out_is_press, out_position, out_param_a, out_param_b,
                  out_time, out_last, output ready);
endinterface

// ===== rtl/lpks_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module lpks_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                                      clk_i,
  input  logic                                      we_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr_i,
  input  logic [WIDTH-1:0]                          wdata_i,
  input  logic                                      re_i,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr_i,
  output logic [WIDTH-1:0]                          rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/lpks_seq.sv =====
// Sequencer for the key stack: walks the press-order list held in slot RAMs,
// emits release/press words. Depends on lpks_pkg and lpks_ram.
`timescale 1ns / 1ps

module lpks_seq #(
  parameter int unsigned ENTRIES = lpks_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpks_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  lpks_pkg::req_t                in_req_i,
  output logic                          ev_valid_o,
  output lpks_pkg::ev_t                 ev_o,
  input  logic                          ev_ready_i
);
  import lpks_pkg::*;

  localparam int unsigned IW   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned LW   = $clog2(ENTRIES + 1);
  localparam int unsigned CMPW = (LW > LIMIT_W) ? LW : LIMIT_W;
  localparam int unsigned DW   = POS_W + 2 * PARAM_W;
  localparam logic [LW-1:0] NONE = LW'(ENTRIES);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_PR_RD    = 4'd1;
  localparam logic [3:0] S_PR_REL   = 4'd2;
  localparam logic [3:0] S_DROP_CHK = 4'd3;
  localparam logic [3:0] S_DROP_UPD = 4'd4;
  localparam logic [3:0] S_INS1     = 4'd5;
  localparam logic [3:0] S_INS2     = 4'd6;
  localparam logic [3:0] S_PR_OUT   = 4'd7;
  localparam logic [3:0] S_RL_RD    = 4'd8;
  localparam logic [3:0] S_RL_CMP   = 4'd9;
  localparam logic [3:0] S_RL_REL   = 4'd10;
  localparam logic [3:0] S_RL_RD2   = 4'd11;
  localparam logic [3:0] S_RL_PRS   = 4'd12;

  logic [3:0]         state_q, state_d;
  req_t               req_q, req_d;
  logic [LIMIT_W-1:0] lim_q, lim_d;
  logic [ENTRIES-1:0] in_use_q, in_use_d;
  logic [LW-1:0]      cnt_q, cnt_d;
  logic [IW-1:0]      oldest_q, oldest_d;
  logic [LW-1:0]      newest_q, newest_d;
  logic [LW-1:0]      walk_q, walk_d;
  logic [LW-1:0]      older_q, older_d;
  logic [IW-1:0]      f_q, f_d;

  logic               rd_en;
  logic [IW-1:0]      rd_addr;
  logic               d_we, o_we, n_we;
  logic [IW-1:0]      d_waddr, o_waddr, n_waddr;
  logic [DW-1:0]      d_wdata, d_rdata;
  logic [LW-1:0]      o_wdata, o_rdata, n_wdata, n_rdata;

  logic [POS_W-1:0]   rd_pos;
  logic [PARAM_W-1:0] rd_a, rd_b;
  logic               hit;
  logic [CMPW-1:0]    lim_ext, lim_eff;
  logic               drop_need;
  logic [IW-1:0]      free_idx;

  // slot data, older links, newer links
  lpks_ram #(.WIDTH(DW), .DEPTH(ENTRIES)) u_data (
    .clk_i, .we_i(d_we), .waddr_i(d_waddr), .wdata_i(d_wdata),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(d_rdata)
  );
  lpks_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_older (
    .clk_i, .we_i(o_we), .waddr_i(o_waddr), .wdata_i(o_wdata),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(o_rdata)
  );
  lpks_ram #(.WIDTH(LW), .DEPTH(ENTRIES)) u_newer (
    .clk_i, .we_i(n_we), .waddr_i(n_waddr), .wdata_i(n_wdata),
    .re_i(rd_en), .raddr_i(rd_addr), .rdata_o(n_rdata)
  );

  assign rd_pos = d_rdata[DW-1 -: POS_W];
  assign rd_a   = d_rdata[2*PARAM_W-1 -: PARAM_W];
  assign rd_b   = d_rdata[PARAM_W-1:0];
  assign hit    = (rd_pos == req_q.key_position) && (rd_a == req_q.param_a) &&
                  (rd_b == req_q.param_b);

  // limit of zero acts as one, above the depth acts as the depth
  always_comb begin
    lim_ext = CMPW'(lim_q);
    lim_eff = lim_ext;
    if (lim_ext == '0) begin
      lim_eff = CMPW'(1);
    end else if (lim_ext > CMPW'(ENTRIES)) begin
      lim_eff = CMPW'(ENTRIES);
    end
  end
  assign drop_need = (CMPW'(cnt_q) >= lim_eff);

  // lowest free slot
  always_comb begin
    free_idx = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_idx = IW'(i);
      end
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

  always_comb begin
    state_d  = state_q;
    req_d    = req_q;
    lim_d    = cfg_we_i ? cfg_wdata_i : lim_q;
    in_use_d = in_use_q;
    cnt_d    = cnt_q;
    oldest_d = oldest_q;
    newest_d = newest_q;
    walk_d   = walk_q;
    older_d  = older_q;
    f_d      = f_q;

    rd_en   = 1'b0;
    rd_addr = '0;
    d_we    = 1'b0;
    d_waddr = '0;
    d_wdata = {req_q.key_position, req_q.param_a, req_q.param_b};
    o_we    = 1'b0;
    o_waddr = '0;
    o_wdata = NONE;
    n_we    = 1'b0;
    n_waddr = '0;
    n_wdata = NONE;

    ev_valid_o      = 1'b0;
    ev_o.is_press   = 1'b0;
    ev_o.position   = rd_pos;
    ev_o.param_a    = rd_a;
    ev_o.param_b    = rd_b;
    ev_o.evt_time   = req_q.event_time;
    ev_o.last       = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          req_d = in_req_i;
          if (in_req_i.req_type == REQ_PRESS) begin
            state_d = (newest_q != NONE) ? S_PR_RD : S_DROP_CHK;
          end else if (newest_q != NONE) begin
            walk_d  = newest_q;
            state_d = S_RL_RD;
          end
        end
      end
      S_PR_RD: begin
        rd_en   = 1'b1;
        rd_addr = newest_q[IW-1:0];
        state_d = S_PR_REL;
      end
      S_PR_REL: begin
        // a press always follows, so this release is never last
        ev_valid_o = ev_ready_i;
        if (ev_ready_i) begin
          state_d = S_DROP_CHK;
        end
      end
      S_DROP_CHK: begin
        if (drop_need) begin
          rd_en   = 1'b1;
          rd_addr = oldest_q;
          state_d = S_DROP_UPD;
        end else begin
          state_d = S_INS1;
        end
      end
      S_DROP_UPD: begin
        in_use_d[oldest_q] = 1'b0;
        cnt_d              = cnt_q - LW'(1);
        if (n_rdata == NONE) begin
          newest_d = NONE;
          oldest_d = '0;
        end else begin
          o_we     = 1'b1;
          o_waddr  = n_rdata[IW-1:0];
          o_wdata  = NONE;
          oldest_d = n_rdata[IW-1:0];
        end
        state_d = S_DROP_CHK;
      end
      S_INS1: begin
        d_we               = 1'b1;
        d_waddr            = free_idx;
        o_we               = 1'b1;
        o_waddr            = free_idx;
        o_wdata            = newest_q;
        n_we               = 1'b1;
        n_waddr            = free_idx;
        n_wdata            = NONE;
        in_use_d[free_idx] = 1'b1;
        cnt_d              = cnt_q + LW'(1);
        f_d                = free_idx;
        if (newest_q != NONE) begin
          state_d = S_INS2;
        end else begin
          oldest_d = free_idx;
          newest_d = LW'(free_idx);
          state_d  = S_PR_OUT;
        end
      end
      S_INS2: begin
        n_we     = 1'b1;
        n_waddr  = newest_q[IW-1:0];
        n_wdata  = LW'(f_q);
        newest_d = LW'(f_q);
        state_d  = S_PR_OUT;
      end
      S_PR_OUT: begin
        ev_o.is_press = 1'b1;
        ev_o.position = req_q.key_position;
        ev_o.param_a  = req_q.param_a;
        ev_o.param_b  = req_q.param_b;
        ev_o.last     = 1'b1;
        ev_valid_o    = ev_ready_i;
        if (ev_ready_i) begin
          state_d = S_IDLE;
        end
      end
      S_RL_RD: begin
        rd_en   = 1'b1;
        rd_addr = walk_q[IW-1:0];
        state_d = S_RL_CMP;
      end
      S_RL_CMP: begin
        if (hit) begin
          in_use_d[walk_q[IW-1:0]] = 1'b0;
          cnt_d                    = cnt_q - LW'(1);
          if (walk_q == newest_q) begin
            older_d = o_rdata;
            state_d = S_RL_REL;
          end else begin
            // unlink a buried entry: no words emitted
            if (n_rdata != NONE) begin
              o_we    = 1'b1;
              o_waddr = n_rdata[IW-1:0];
              o_wdata = o_rdata;
            end
            if (o_rdata != NONE) begin
              n_we    = 1'b1;
              n_waddr = o_rdata[IW-1:0];
              n_wdata = n_rdata;
            end else if (n_rdata != NONE) begin
              oldest_d = n_rdata[IW-1:0];
            end
            state_d = S_IDLE;
          end
        end else if (o_rdata == NONE) begin
          state_d = S_IDLE;
        end else begin
          walk_d  = o_rdata;
          state_d = S_RL_RD;
        end
      end
      S_RL_REL: begin
        ev_o.last  = (older_q == NONE);
        ev_valid_o = ev_ready_i;
        if (ev_ready_i) begin
          newest_d = older_q;
          if (older_q != NONE) begin
            n_we    = 1'b1;
            n_waddr = older_q[IW-1:0];
            n_wdata = NONE;
            state_d = S_RL_RD2;
          end else begin
            oldest_d = '0;
            state_d  = S_IDLE;
          end
        end
      end
      S_RL_RD2: begin
        rd_en   = 1'b1;
        rd_addr = older_q[IW-1:0];
        state_d = S_RL_PRS;
      end
      S_RL_PRS: begin
        ev_o.is_press = 1'b1;
        ev_o.last     = 1'b1;
        ev_valid_o    = ev_ready_i;
        if (ev_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      lim_q    <= LIMIT_RST;
      in_use_q <= '0;
      cnt_q    <= '0;
      oldest_q <= '0;
      newest_q <= NONE;
    end else begin
      state_q  <= state_d;
      lim_q    <= lim_d;
      in_use_q <= in_use_d;
      cnt_q    <= cnt_d;
      oldest_q <= oldest_d;
      newest_q <= newest_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q   <= req_d;
    walk_q  <= walk_d;
    older_q <= older_d;
    f_q     <= f_d;
  end

endmodule

// ===== rtl/last_press_priority_key_stack.sv =====
// A press emits a release of the newest entry if the list is not empty, drops oldest entries
// until the count is under the limit, then inserts and emits the press; a release walks the list.
// Words are taken one at a time: a new word is accepted only when the sequencer is idle again,
// after the slot RAM walk for the previous word.
// Reset: asynchronous, clears in-use flags at once, empties the list, limit = 10.
// Depends on lpks_pkg, lpks_if and lpks_seq.
`timescale 1ns / 1ps

module last_press_priority_key_stack #(
  parameter int unsigned ENTRIES = lpks_pkg::ENTRIES_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [lpks_pkg::LIMIT_W-1:0]  cfg_wdata_i,
  lpks_in_if.sink                       in_i,
  lpks_out_if.source                    out_o
);
  import lpks_pkg::*;

  req_t in_req;
  ev_t  ev, ev_q;
  logic ev_valid, ev_ready;
  logic ov_q, ov_d;

  assign in_req.req_type     = in_i.req_type;
  assign in_req.key_position = in_i.key_position;
  assign in_req.param_a      = in_i.param_a;
  assign in_req.param_b      = in_i.param_b;
  assign in_req.event_time   = in_i.event_time;

  lpks_seq #(.ENTRIES(ENTRIES)) u_seq (
    .clk_i,
    .rst_ni,
    .cfg_we_i,
    .cfg_wdata_i,
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .in_req_i   (in_req),
    .ev_valid_o (ev_valid),
    .ev_o       (ev),
    .ev_ready_i (ev_ready)
  );

  // output register: free when empty or being taken this cycle
  assign ev_ready = !ov_q || out_o.ready;

  always_comb begin
    ov_d = ov_q;
    if (ev_valid) begin
      ov_d = 1'b1;
    end else if (out_o.ready) begin
      ov_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ov_q <= 1'b0;
    end else begin
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ev_valid) begin
      ev_q <= ev;
    end
  end

  assign out_o.valid        = ov_q;
  assign out_o.out_is_press = ev_q.is_press;
  assign out_o.out_position = ev_q.position;
  assign out_o.out_param_a  = ev_q.param_a;
  assign out_o.out_param_b  = ev_q.param_b;
  assign out_o.out_time     = ev_q.evt_time;
  assign out_o.out_last     = ev_q.last;

endmodule

// ===== rtl/lpks_chk.sv =====
// Port-level checks for the key stack, bound to the top level.
// Depends on last_press_priority_key_stack.
`timescale 1ns / 1ps

module lpks_chk (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i,
  input logic out_is_press_i,
  input logic out_last_i
);

  // a stalled word keeps its press and last flags
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_is_press_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

  // only a release can be followed by another result
  a_first_is_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_last_i |-> !out_is_press_i)
    else $error("non-final result is a press");

  // when idle, any buffered word closes its group
  a_idle_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_i && out_valid_i |-> out_last_i)
    else $error("idle with an unfinished group pending");

  a_valid_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("output valid dropped while stalled");

endmodule

bind last_press_priority_key_stack lpks_chk u_lpks_chk (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_ready_i     (in_i.ready),
  .out_valid_i    (out_o.valid),
  .out_ready_i    (out_o.ready),
  .out_is_press_i (out_o.out_is_press),
  .out_last_i     (out_o.out_last)
);

// ===== verif/tb_last_press_priority_key_stack.sv =====
// Self-checking bench for last_press_priority_key_stack: directed and random press/release
// words, limit changes between phases, input gaps and output stall patterns.
// Depends on lpks_pkg, lpks_if and last_press_priority_key_stack from the rtl folder.
`timescale 1ns / 1ps

module tb;
  import lpks_pkg::*;

  localparam int N = ENTRIES_DEF;
  localparam logic KEY_RELEASE = !REQ_PRESS;
  localparam int SETTLE_CYCLES = 80;
  localparam int QUIET_LIMIT = 3000;
  localparam int PHASE_WORDS = 150;

  typedef enum int {RX_OPEN, RX_RANDOM, RX_SPARSE, RX_PERIODIC} rx_mode_e;

  // Predicts the emitted words from its own copy of the held-key list.
  class key_stack_scoreboard;
    bit                 used[N];
    logic [POS_W-1:0]   kpos[N];
    logic [PARAM_W-1:0] ka[N];
    logic [PARAM_W-1:0] kb[N];
    int                 older[N];
    int                 newer[N];
    int                 oldest_idx;
    int                 newest_idx;
    logic [LIMIT_W-1:0] limit;
    ev_t                pending[$];
    int                 errors;

    function new();
      limit = LIMIT_RST;
      for (int i = 0; i < N; i++) begin
        used[i] = 1'b0;
        older[i] = N;
        newer[i] = N;
      end
      oldest_idx = 0;
      newest_idx = N;
      errors = 0;
    endfunction

    function int held();
      int c;
      c = 0;
      for (int i = 0; i < N; i++) c += used[i];
      return c;
    endfunction

    function void drop_oldest();
      int nx;
      if (newest_idx == N) return;
      used[oldest_idx] = 1'b0;
      nx = newer[oldest_idx];
      if (nx == N) begin
        newest_idx = N;
        oldest_idx = 0;
      end else begin
        older[nx] = N;
        oldest_idx = nx;
      end
    endfunction

    function ev_t slot_word(bit press, int s, logic [TIME_W-1:0] t);
      ev_t e;
      e.is_press = press;
      e.position = kpos[s];
      e.param_a = ka[s];
      e.param_b = kb[s];
      e.evt_time = t;
      e.last = 1'b0;
      return e;
    endfunction

    function void note_input(req_t r);
      ev_t evs[$];
      int  lim;
      int  f;
      int  s;
      int  m;
      int  o;
      int  w;
      if (r.req_type == REQ_PRESS) begin
        lim = limit;
        if (lim < 1) lim = 1;
        if (lim > N) lim = N;
        if (newest_idx != N) evs.push_back(slot_word(1'b0, newest_idx, r.event_time));
        for (int g = 0; g <= N && held() >= lim; g++) drop_oldest();
        f = N;
        for (int i = 0; i < N; i++) begin
          if (!used[i]) begin
            f = i;
            break;
          end
        end
        if (f != N) begin
          used[f] = 1'b1;
          kpos[f] = r.key_position;
          ka[f] = r.param_a;
          kb[f] = r.param_b;
          older[f] = newest_idx;
          newer[f] = N;
          if (newest_idx != N) newer[newest_idx] = f;
          else oldest_idx = f;
          newest_idx = f;
          evs.push_back(slot_word(1'b1, f, r.event_time));
        end
      end else begin
        // search newest to oldest
        s = newest_idx;
        m = N;
        for (int g = 0; g < N && s != N; g++) begin
          if (kpos[s] == r.key_position && ka[s] == r.param_a && kb[s] == r.param_b) begin
            m = s;
            break;
          end
          s = older[s];
        end
        if (m != N) begin
          o = older[m];
          used[m] = 1'b0;
          if (m == newest_idx) begin
            evs.push_back(slot_word(1'b0, m, r.event_time));
            newest_idx = o;
            if (o != N) begin
              newer[o] = N;
              evs.push_back(slot_word(1'b1, o, r.event_time));
            end else begin
              oldest_idx = 0;
            end
          end else begin
            w = newer[m];
            if (w != N) older[w] = o;
            if (o != N) newer[o] = w;
            else if (w != N) oldest_idx = w;
          end
        end
      end
      if (evs.size() > 0) evs[evs.size()-1].last = 1'b1;
      foreach (evs[i]) pending.push_back(evs[i]);
    endfunction

    function void check_result(ev_t got);
      ev_t   e;
      string bad;
      bad = "";
      errors += (pending.size() == 0);
      if (pending.size() == 0) begin
        if (errors <= 10)
          $display("unexpected word: press=%0d pos=%0h a=%0h b=%0h t=%0h last=%0d",
                   got.is_press, got.position, got.param_a, got.param_b, got.evt_time,
                   got.last);
        return;
      end
      e = pending.pop_front();
      if (got.is_press !== e.is_press) bad = {bad, " is_press"};
      if (got.position !== e.position) bad = {bad, " position"};
      if (got.param_a !== e.param_a) bad = {bad, " param_a"};
      if (got.param_b !== e.param_b) bad = {bad, " param_b"};
      if (got.evt_time !== e.evt_time) bad = {bad, " time"};
      if (got.last !== e.last) bad = {bad, " last"};
      if (bad != "") begin
        errors++;
        if (errors <= 10)
          $display({"mismatch on%s: expected press=%0d pos=%0h a=%0h b=%0h t=%0h last=%0d,",
                    " got press=%0d pos=%0h a=%0h b=%0h t=%0h last=%0d"},
                   bad, e.is_press, e.position, e.param_a, e.param_b, e.evt_time, e.last,
                   got.is_press, got.position, got.param_a, got.param_b, got.evt_time,
                   got.last);
      end
    endfunction

    // Data of a held key, as a release word.
    function req_t held_key(bit newest_only);
      req_t r;
      int   k;
      int   n;
      r = '0;
      r.req_type = KEY_RELEASE;
      k = newest_idx;
      if (!newest_only) begin
        n = $urandom_range(0, held() - 1);
        for (int i = 0; i < N; i++) begin
          if (used[i]) begin
            if (n == 0) begin
              k = i;
              break;
            end
            n--;
          end
        end
      end
      r.key_position = kpos[k];
      r.param_a = ka[k];
      r.param_b = kb[k];
      return r;
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               cfg_we;
  logic [LIMIT_W-1:0] cfg_wdata;
  int                 quiet_cycles;
  int                 burst_left;
  int                 gap_max;

  lpks_in_if  in_if();
  lpks_out_if out_if();

  key_stack_scoreboard sb = new();

  last_press_priority_key_stack uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (in_if),
    .out_o       (out_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  function automatic req_t mk_req(logic rq, logic [POS_W-1:0] p, logic [PARAM_W-1:0] a,
                                  logic [PARAM_W-1:0] b, logic [TIME_W-1:0] t);
    req_t r;
    r.req_type = rq;
    r.key_position = p;
    r.param_a = a;
    r.param_b = b;
    r.event_time = t;
    return r;
  endfunction

  function automatic logic [PARAM_W-1:0] rand_param();
    case ($urandom_range(0, 4))
      0: return '0;
      1: return '1;
      2: return 32'h8000_0000;
      3: return 32'd4;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [TIME_W-1:0] rand_time();
    return TIME_W'({$urandom(), $urandom()});
  endfunction

  // Half from a small pool so that keys collide, half fully random.
  function automatic req_t rand_key(logic rq);
    if ($urandom_range(0, 1))
      return mk_req(rq, POS_W'($urandom_range(0, 7)), rand_param(), rand_param(), rand_time());
    return mk_req(rq, POS_W'($urandom()), $urandom(), $urandom(), rand_time());
  endfunction

  // Called at a rising edge; returns at the edge where the word is taken, or after a random gap.
  task automatic send_word(req_t r);
    in_if.valid <= 1'b1;
    in_if.req_type <= r.req_type;
    in_if.key_position <= r.key_position;
    in_if.param_a <= r.param_a;
    in_if.param_b <= r.param_b;
    in_if.event_time <= r.event_time;
    do @(posedge clk_i); while (!(in_if.valid && in_if.ready));
    sb.note_input(r);
    burst_left--;
    if (burst_left <= 0) begin
      int gap;
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        in_if.valid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  // A release that finds nothing leaves no word behind, so give the walk time to finish.
  task automatic wait_idle();
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(logic [LIMIT_W-1:0] v);
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk_i);
    cfg_we <= 1'b0;
    sb.limit = v;
  endtask

  task automatic run_phase(int words, int gmax);
    int   done;
    int   roll;
    req_t r;
    done = 0;
    gap_max = gmax;
    while (done < words) begin
      roll = $urandom_range(0, 99);
      if (roll < 50 || (sb.held() == 0 && roll < 90)) begin
        send_word(rand_key(REQ_PRESS));
        done++;
      end else if (roll < 90) begin
        r = sb.held_key($urandom_range(0, 9) < 4);
        r.event_time = rand_time();
        send_word(r);
        done++;
      end else if (roll < 95 && sb.held() > 0) begin
        // near miss: one bit off a held key
        r = sb.held_key(1'b0);
        r.event_time = rand_time();
        case ($urandom_range(0, 2))
          0: r.key_position[$urandom_range(0, POS_W-1)] ^= 1'b1;
          1: r.param_a[$urandom_range(0, PARAM_W-1)] ^= 1'b1;
          default: r.param_b[$urandom_range(0, PARAM_W-1)] ^= 1'b1;
        endcase
        send_word(r);
        done++;
      end else begin
        send_word(rand_key(KEY_RELEASE));
        done++;
      end
    end
    in_if.valid <= 1'b0;
  endtask

  // Receiver stall patterns, each held for a random stretch.
  initial begin
    rx_mode_e mode;
    int       run;
    int       tick;
    out_if.ready = 1'b0;
    tick = 0;
    @(posedge rst_ni);
    forever begin
      mode = rx_mode_e'($urandom_range(0, 3));
      run = $urandom_range(20, 200);
      repeat (run) begin
        @(posedge clk_i);
        tick++;
        case (mode)
          RX_OPEN:     out_if.ready <= 1'b1;
          RX_RANDOM:   out_if.ready <= $urandom_range(0, 1);
          RX_SPARSE:   out_if.ready <= ($urandom_range(0, 3) == 0);
          RX_PERIODIC: out_if.ready <= (tick % 5 != 0);
          default:     out_if.ready <= 1'b1;
        endcase
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_if.valid && out_if.ready)
      sb.check_result({out_if.out_is_press, out_if.out_position, out_if.out_param_a,
                       out_if.out_param_b, out_if.out_time, out_if.out_last});
  end

  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("timeout: no word moved for %0d cycles", QUIET_LIMIT);
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    logic [LIMIT_W-1:0] limits[9];
    logic [TIME_W-1:0]  t;
    rst_ni = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_if.valid = 1'b0;
    in_if.req_type = REQ_PRESS;
    in_if.key_position = '0;
    in_if.param_a = '0;
    in_if.param_b = '0;
    in_if.event_time = '0;
    quiet_cycles = 0;
    burst_left = 1;
    gap_max = 3;
    limits = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd3, 5'd17, 5'd2, 5'd12, 5'd5};
    limits[8] = $urandom_range(0, 31);
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed, at the reset limit
    t = rand_time();
    send_word(mk_req(KEY_RELEASE, '0, '0, '0, '0));             // empty list
    send_word(mk_req(REQ_PRESS, '1, '1, '1, '1));
    send_word(mk_req(REQ_PRESS, '0, '0, '0, '0));
    send_word(mk_req(KEY_RELEASE, '0, '0, '0, t));               // newest: re-press older
    send_word(mk_req(REQ_PRESS, 8'd1, 32'd1, 32'd2, t));
    send_word(mk_req(KEY_RELEASE, '1, '1, '1, t));               // not newest: silent
    send_word(mk_req(KEY_RELEASE, 8'd1, 32'd1, 32'd2, t));       // last one held
    for (int i = 0; i < 12; i++)                                 // runs past the limit
      send_word(mk_req(REQ_PRESS, POS_W'(10 + i), i, ~i, rand_time()));
    send_word(mk_req(KEY_RELEASE, 8'd21, 32'd11, ~32'd11 ^ 32'd1, t));
    send_word(mk_req(KEY_RELEASE, 8'd15, 32'd5, ~32'd5, t));
    send_word(mk_req(REQ_PRESS, 8'd21, 32'd11, ~32'd11, t));      // duplicate key
    send_word(mk_req(KEY_RELEASE, 8'd21, 32'd11, ~32'd11, rand_time()));
    in_if.valid <= 1'b0;

    foreach (limits[p]) begin
      wait_idle();
      write_limit(limits[p]);
      run_phase(PHASE_WORDS, (p % 3 == 0) ? 0 : 12);
    end

    wait_idle();
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("*** PASSED ***");
    else
      $display("*** FAILED ***");
    $finish;
  end

endmodule

// ===== last_press_priority_key_stack.f =====
rtl/lpks_pkg.sv
rtl/lpks_if.sv
rtl/lpks_ram.sv
rtl/lpks_seq.sv
rtl/last_press_priority_key_stack.sv
rtl/lpks_chk.sv
verif/tb_last_press_priority_key_stack.sv
